>>> sv/wpanf_pkg.sv
// wpanf_pkg: types, constants and helper functions for the weekly point finder.
// No dependencies; every other file of the block but wpanf_stream_if uses it.

package wpanf_pkg;

    // Sizes fixed by the point and field formats
    localparam int MAX_SLOTS           = 8;
    localparam int DEFAULT_POINT_SLOTS = 8;
    localparam int IDX_W               = 3;
    localparam int MIN_W               = 11;
    localparam int MASK_W              = 7;
    localparam int PT_W                = 19;
    localparam int PAIR_W              = 38;
    localparam int CNT_W               = 4;
    localparam int CFG_IDX_W           = 3;
    localparam int DIST_W              = 14;
    localparam int OUT_MIN_W           = 16;

    localparam logic [MIN_W-1:0]     DAY_MINUTES  = 11'd1440;
    localparam logic [DIST_W-1:0]    WEEK_MINUTES = 14'd10080;
    localparam logic [OUT_MIN_W-1:0] NONE_MINUTES = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_3      = 3'd4;

    typedef struct packed {
        logic              enable;
        logic [MASK_W-1:0] mask;
        logic [MIN_W-1:0]  minute;
    } t_point;

    typedef t_point [MAX_SLOTS-1:0] t_point_vec;

    typedef struct packed {
        logic [2:0]       query_weekday;
        logic [MIN_W-1:0] query_minute;
    } t_query;

    typedef struct packed {
        logic                 active_found;
        logic [IDX_W-1:0]     active_slot;
        logic                 next_found;
        logic [IDX_W-1:0]     next_slot;
        logic [OUT_MIN_W-1:0] next_minutes;
    } t_result;

    // Per-point day offsets after the first stage
    typedef struct packed {
        logic             act_ok;
        logic [2:0]       act_k;
        logic             nxt_ok;
        logic [2:0]       nxt_k;
        logic [MIN_W-1:0] minute;
    } t_pre;

    typedef t_pre [MAX_SLOTS-1:0] t_pre_vec;

    // One candidate in the minimum search
    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] span;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    typedef struct packed {
        t_cand act;
        t_cand nxt;
    } t_lane;

    typedef t_lane [MAX_SLOTS-1:0] t_lane_vec;

    // k * 1440 for k in 0..7
    function automatic logic [DIST_W-1:0] day_offset(input logic [2:0] k);
        logic [DIST_W-1:0] v;
        case (k)
            3'd0:    v = 14'd0;
            3'd1:    v = 14'd1440;
            3'd2:    v = 14'd2880;
            3'd3:    v = 14'd4320;
            3'd4:    v = 14'd5760;
            3'd5:    v = 14'd7200;
            3'd6:    v = 14'd8640;
            3'd7:    v = 14'd10080;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // lo has the lower index and wins ties
    function automatic t_cand pick(input t_cand lo, input t_cand hi);
        t_cand w;
        if (lo.ok && (!hi.ok || lo.span <= hi.span))
            w = lo;
        else
            w = hi;
        return w;
    endfunction

endpackage

>>> sv/wpanf_stream_if.sv
// wpanf_stream_if: valid/ready channel carrying one payload of type T.
// Uses no package itself; payload types come from wpanf_pkg at instantiation.

interface wpanf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/wpanf_cfg_regs.sv
// wpanf_cfg_regs: point count and point storage, written through the config port.
// Depends on wpanf_pkg.

module wpanf_cfg_regs #(
    parameter int POINT_SLOTS = wpanf_pkg::DEFAULT_POINT_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wpanf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpanf_pkg::PAIR_W-1:0]        i_cfg_data,
    output logic [wpanf_pkg::CNT_W-1:0]         o_count,
    output wpanf_pkg::t_point_vec               o_points
);

    logic [wpanf_pkg::CNT_W-1:0] r_count;
    wpanf_pkg::t_point           r_point [POINT_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < POINT_SLOTS; i++) begin
                r_point[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == wpanf_pkg::REG_POINT_COUNT) begin
                r_count <= i_cfg_data[wpanf_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < POINT_SLOTS; i++) begin
                if (i_cfg_index == wpanf_pkg::REG_PAIR_0 +
                        wpanf_pkg::CFG_IDX_W'(i >> 1)) begin
                    r_point[i] <= (i % 2 == 1) ?
                        i_cfg_data[2*wpanf_pkg::PT_W-1:wpanf_pkg::PT_W] :
                        i_cfg_data[wpanf_pkg::PT_W-1:0];
                end
            end
        end
    end

    assign o_count = r_count;

    // slots beyond the configured storage read as disabled
    always_comb begin
        o_points = '0;
        for (int i = 0; i < POINT_SLOTS; i++) begin
            o_points[i] = r_point[i];
        end
    end

endmodule

>>> sv/wpanf_point_eval.sv
// wpanf_point_eval: stages 1 and 2, per-point day offset then age and distance.
// Depends on wpanf_pkg.

module wpanf_point_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  wpanf_pkg::t_query           i_query,
    input  logic [wpanf_pkg::CNT_W-1:0] i_count,
    input  wpanf_pkg::t_point_vec       i_points,
    output logic                        o_valid,
    input  logic                        i_ready,
    output wpanf_pkg::t_lane_vec        o_lanes
);

    // stage 1
    logic                          r_v1;
    wpanf_pkg::t_pre_vec           r_pre;
    wpanf_pkg::t_pre_vec           n_pre;
    logic [wpanf_pkg::MIN_W-1:0]   r_now;
    logic [wpanf_pkg::MIN_W-1:0]   n_now;
    logic                          rdy1;
    // stage 2
    logic                          r_v2;
    wpanf_pkg::t_lane_vec          r_lane;
    wpanf_pkg::t_lane_vec          n_lane;
    logic                          rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        logic [2:0]                  wd;
        logic [7:0]                  mask8;
        logic [6:0]                  av;
        logic [7:0]                  nv;
        logic [2:0]                  d;
        logic [3:0]                  s;
        logic                        le;
        logic                        use_pt;
        wd    = (i_query.query_weekday == 3'd7) ? 3'd0 : i_query.query_weekday;
        n_now = (i_query.query_minute >= wpanf_pkg::DAY_MINUTES) ?
                wpanf_pkg::DAY_MINUTES - 11'd1 : i_query.query_minute;
        for (int i = 0; i < wpanf_pkg::MAX_SLOTS; i++) begin
            mask8  = {1'b0, i_points[i].mask};
            use_pt = (wpanf_pkg::CNT_W'(i) < i_count) && i_points[i].enable &&
                     (i_points[i].minute < wpanf_pkg::DAY_MINUTES);
            le     = i_points[i].minute <= n_now;
            // masks rotated so bit j is the day j back (av) or j ahead (nv)
            for (int j = 0; j < 7; j++) begin
                d     = (wd >= 3'(j)) ? wd - 3'(j) : wd + 3'(7 - j);
                av[j] = mask8[d];
                s     = {1'b0, wd} + 4'(j);
                d     = (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
                nv[j] = mask8[d];
            end
            nv[7] = mask8[wd];   // same weekday next week
            av[0] = av[0] & le;
            nv[0] = nv[0] & ~le;
            n_pre[i].act_k = 3'd0;
            for (int j = 6; j >= 0; j--) begin
                if (av[j]) n_pre[i].act_k = 3'(j);
            end
            n_pre[i].nxt_k = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (nv[j]) n_pre[i].nxt_k = 3'(j);
            end
            n_pre[i].act_ok = use_pt && (|av);
            n_pre[i].nxt_ok = use_pt && (|nv);
            n_pre[i].minute = i_points[i].minute;
        end
    end

    always_comb begin
        for (int i = 0; i < wpanf_pkg::MAX_SLOTS; i++) begin
            n_lane[i].act.ok   = r_pre[i].act_ok;
            n_lane[i].act.span = wpanf_pkg::day_offset(r_pre[i].act_k) +
                                 wpanf_pkg::DIST_W'(r_now) -
                                 wpanf_pkg::DIST_W'(r_pre[i].minute);
            n_lane[i].act.idx  = wpanf_pkg::IDX_W'(i);
            n_lane[i].nxt.ok   = r_pre[i].nxt_ok;
            n_lane[i].nxt.span = wpanf_pkg::day_offset(r_pre[i].nxt_k) +
                                 wpanf_pkg::DIST_W'(r_pre[i].minute) -
                                 wpanf_pkg::DIST_W'(r_now);
            n_lane[i].nxt.idx  = wpanf_pkg::IDX_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
        if (rdy1 && i_valid) begin
            r_pre <= n_pre;
            r_now <= n_now;
        end
        if (rdy2 && r_v1) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_v2;
    assign o_lanes = r_lane;

endmodule

>>> sv/wpanf_min_tree.sv
// wpanf_min_tree: stages 3 and 4, registered minimum search over the lanes.
// Depends on wpanf_pkg.

module wpanf_min_tree (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wpanf_pkg::t_lane_vec i_lanes,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wpanf_pkg::t_result   o_result
);

    logic                  r_v3;
    wpanf_pkg::t_lane      r_half [2];
    wpanf_pkg::t_lane      n_half [2];
    logic                  rdy3;
    logic                  r_v4;
    wpanf_pkg::t_result    r_res;
    wpanf_pkg::t_result    n_res;
    logic                  rdy4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    // 8 -> 2, two compare levels
    always_comb begin
        wpanf_pkg::t_lane l1 [4];
        for (int i = 0; i < 4; i++) begin
            l1[i].act = wpanf_pkg::pick(i_lanes[2*i].act, i_lanes[2*i+1].act);
            l1[i].nxt = wpanf_pkg::pick(i_lanes[2*i].nxt, i_lanes[2*i+1].nxt);
        end
        for (int i = 0; i < 2; i++) begin
            n_half[i].act = wpanf_pkg::pick(l1[2*i].act, l1[2*i+1].act);
            n_half[i].nxt = wpanf_pkg::pick(l1[2*i].nxt, l1[2*i+1].nxt);
        end
    end

    // 2 -> 1 and result formatting
    always_comb begin
        wpanf_pkg::t_cand a;
        wpanf_pkg::t_cand b;
        a = wpanf_pkg::pick(r_half[0].act, r_half[1].act);
        b = wpanf_pkg::pick(r_half[0].nxt, r_half[1].nxt);
        n_res.active_found = a.ok;
        n_res.active_slot  = a.ok ? a.idx : '0;
        n_res.next_found   = b.ok;
        n_res.next_slot    = b.ok ? b.idx : '0;
        n_res.next_minutes = b.ok ? wpanf_pkg::OUT_MIN_W'(b.span) :
                                    wpanf_pkg::NONE_MINUTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) r_v3 <= i_valid;
            if (rdy4) r_v4 <= r_v3;
        end
        if (rdy3 && i_valid) begin
            r_half <= n_half;
        end
        if (rdy4 && r_v3) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r_res;

endmodule

>>> sv/weekly_point_active_next_finder.sv
// weekly_point_active_next_finder: top level of the weekly point finder.
// Depends on wpanf_pkg, wpanf_stream_if, wpanf_cfg_regs, wpanf_point_eval, wpanf_min_tree.

// Takes one query transaction (weekday, minute of day) per clock, back-pressure
// aside, and returns one result transaction: the active point (most recent
// occurrence in the past week, today only if its minute is not after now) and
// the next point (fewest minutes ahead, 1..10080, a point at exactly now being a
// week ahead). Ties go to the lowest index; not-found gives index 0 and, for the
// distance, 65535. Throughput is one transaction per cycle while the output is not
// stalled. There are four register stages: day offsets per point, age and distance per
// point, a two-level compare tree, and the final compare into the output
// register. Every stage has its own valid bit and fills bubbles, so queries keep
// entering while a result waits on the output, until all four stages are full.
// The user must write points through the config port while no transaction is in
// flight; the block does not enforce this. Valid and config registers reset to zero.

module weekly_point_active_next_finder #(
    parameter int POINT_SLOTS = wpanf_pkg::DEFAULT_POINT_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wpanf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpanf_pkg::PAIR_W-1:0]    i_cfg_data,
    wpanf_stream_if.sink                    i_query,
    wpanf_stream_if.source                  o_result
);

    logic [wpanf_pkg::CNT_W-1:0] count;
    wpanf_pkg::t_point_vec       points;
    logic                        eval_valid;
    logic                        tree_ready;
    wpanf_pkg::t_lane_vec        lanes;

    // point storage
    wpanf_cfg_regs #(
        .POINT_SLOTS (POINT_SLOTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_count     (count),
        .o_points    (points)
    );

    // stages 1-2: per-point day offsets, then age and distance
    wpanf_point_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_query.valid),
        .o_ready (i_query.ready),
        .i_query (i_query.data),
        .i_count (count),
        .i_points(points),
        .o_valid (eval_valid),
        .i_ready (tree_ready),
        .o_lanes (lanes)
    );

    // stages 3-4: minimum search, output register
    wpanf_min_tree u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (eval_valid),
        .o_ready  (tree_ready),
        .i_lanes  (lanes),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (o_result.data)
    );

endmodule

>>> sv/wpanf_checker.sv
// wpanf_checker: port-level assertions for the weekly point finder, bound to the top.
// Depends on wpanf_pkg and weekly_point_active_next_finder.

module wpanf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  wpanf_pkg::t_result i_result
);

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
        else $error("result changed while stalled");

    // pipeline empties on reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a point seen in the past week also lies ahead within a week; a point due
    // later today but on no other day is ahead without being active
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result.active_found |-> i_result.next_found)
        else $error("active found without next found");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_result.next_found |->
            i_result.next_minutes == wpanf_pkg::NONE_MINUTES &&
            i_result.next_slot == '0 && i_result.active_slot == '0)
        else $error("not-found result malformed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result.next_found |->
            i_result.next_minutes != '0 &&
            i_result.next_minutes <= 16'(wpanf_pkg::WEEK_MINUTES))
        else $error("next distance out of range");

endmodule

bind weekly_point_active_next_finder wpanf_checker u_wpanf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_result    (o_result.data)
);
